[sv/dhcp_request_option_checker_unit_assert.svh]
// ----------------------------------------------------------------------------
// DHCP request option checker assertion macros
// Shared concurrent-check shorthands, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DHCP_REQUEST_OPTION_CHECKER_UNIT_ASSERT_SVH
`define DHCP_REQUEST_OPTION_CHECKER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DRQC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drqc same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define DRQC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drqc next-cycle check failed");

`endif

[sv/drqc_pkg.sv]
// ----------------------------------------------------------------------------
// DHCP request option checker package
// Word types, per-packet parse state, verdict and walk-phase codes.
// ----------------------------------------------------------------------------
package drqc_pkg;

	localparam int MAX_OPTION_BYTES = 256;
	localparam int MAX_PACKET_BYTES = 2047;
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int LEN_W = 9;
	localparam int MIN_PACKET_BYTES = 241;

	// Header byte offsets
	localparam int POS_OP = 0;
	localparam int POS_HTYPE = 1;
	localparam int POS_HLEN = 2;
	localparam int POS_CHADDR_FIRST = 28;
	localparam int POS_CHADDR_LAST = 33;
	localparam int POS_COOKIE_FIRST = 236;
	localparam int POS_COOKIE_LAST = 239;
	localparam int POS_OPTIONS = 240;

	localparam logic [7:0] OP_REQUEST = 8'd1;
	localparam logic [7:0] HTYPE_ETHER = 8'd1;
	localparam logic [7:0] HLEN_ETHER = 8'd6;
	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_END = 8'd255;

	localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

	// Walk phases
	localparam logic [1:0] PH_CODE = 2'd0;
	localparam logic [1:0] PH_LEN = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// Verdict codes
	localparam logic [2:0] V_OK = 3'd0;
	localparam logic [2:0] V_MODE = 3'd1;
	localparam logic [2:0] V_SHORT = 3'd2;
	localparam logic [2:0] V_NOTREQ = 3'd3;
	localparam logic [2:0] V_COOKIE = 3'd4;
	localparam logic [2:0] V_HW = 3'd5;
	localparam logic [2:0] V_CORRUPT = 3'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
		logic [47:0] source_mac;
		logic from_guest_if;
	} in_word_t;

	typedef struct packed {
		logic [2:0] verdict;
		logic [LEN_W-1:0] options_length;
		logic was_truncated;
		logic [47:0] client_mac;
	} out_word_t;

	typedef struct packed {
		logic [POS_W-1:0] byte_position;
		logic [2:0] first_fail_code;
		logic [1:0] walk_phase;
		logic [7:0] skip_left;
		logic [POS_W-1:0] options_size;
		logic end_seen;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		byte_position: '0,
		first_fail_code: V_OK,
		walk_phase: PH_CODE,
		skip_left: '0,
		options_size: '0,
		end_seen: 1'b0
	};

endpackage

[sv/drqc_step.sv]
// ----------------------------------------------------------------------------
// DHCP request option checker byte step
// Next parse state and result word for one message byte.
// ----------------------------------------------------------------------------
module drqc_step (
	input  drqc_pkg::parse_state_t cur,
	input  drqc_pkg::in_word_t     word,
	input  logic                   ap_mode,
	output drqc_pkg::parse_state_t nxt,
	output drqc_pkg::out_word_t    result
);

	logic [drqc_pkg::POS_W-1:0] pos;
	logic [drqc_pkg::POS_W-1:0] mac_sel;
	logic [7:0] mac_byte;
	logic [7:0] skip_dec;
	logic [2:0] fail_code;
	logic fail;
	logic trunc;

	assign pos = cur.byte_position;
	assign mac_sel = drqc_pkg::POS_W'(drqc_pkg::POS_CHADDR_LAST) - pos;
	assign skip_dec = cur.skip_left - 8'd1;

	// pick the source MAC byte for client address offsets, first byte at offset 28
	always_comb begin
		case (mac_sel[2:0])
			3'd0: mac_byte = word.source_mac[7:0];
			3'd1: mac_byte = word.source_mac[15:8];
			3'd2: mac_byte = word.source_mac[23:16];
			3'd3: mac_byte = word.source_mac[31:24];
			3'd4: mac_byte = word.source_mac[39:32];
			3'd5: mac_byte = word.source_mac[47:40];
			default: mac_byte = 8'd0;
		endcase
	end

	// header checks: at most one per byte
	always_comb begin
		fail = 1'b0;
		fail_code = drqc_pkg::V_OK;
		if (pos == drqc_pkg::POS_W'(drqc_pkg::POS_OP)) begin
			fail = (word.data_byte != drqc_pkg::OP_REQUEST);
			fail_code = drqc_pkg::V_NOTREQ;
		end else if (pos == drqc_pkg::POS_W'(drqc_pkg::POS_HTYPE)) begin
			fail = (word.data_byte != drqc_pkg::HTYPE_ETHER);
			fail_code = drqc_pkg::V_HW;
		end else if (pos == drqc_pkg::POS_W'(drqc_pkg::POS_HLEN)) begin
			fail = (word.data_byte != drqc_pkg::HLEN_ETHER);
			fail_code = drqc_pkg::V_HW;
		end else if (pos >= drqc_pkg::POS_W'(drqc_pkg::POS_CHADDR_FIRST) &&
				pos <= drqc_pkg::POS_W'(drqc_pkg::POS_CHADDR_LAST)) begin
			fail = (word.data_byte != mac_byte);
			fail_code = drqc_pkg::V_HW;
		end else if (pos >= drqc_pkg::POS_W'(drqc_pkg::POS_COOKIE_FIRST) &&
				pos <= drqc_pkg::POS_W'(drqc_pkg::POS_COOKIE_LAST)) begin
			fail = (word.data_byte != drqc_pkg::COOKIE[pos[1:0]]);
			fail_code = drqc_pkg::V_COOKIE;
		end
	end

	always_comb begin
		nxt = cur;
		if (int'(pos) < drqc_pkg::MAX_PACKET_BYTES) begin
			nxt.byte_position = pos + drqc_pkg::POS_W'(1);
			if (fail) begin
				// keep the lowest nonzero code
				if (cur.first_fail_code == drqc_pkg::V_OK || fail_code < cur.first_fail_code)
					nxt.first_fail_code = fail_code;
			end
			if (int'(pos) >= drqc_pkg::POS_OPTIONS) begin
				case (cur.walk_phase)
					drqc_pkg::PH_CODE: begin
						if (word.data_byte == drqc_pkg::OPT_END) begin
							nxt.end_seen = 1'b1;
							nxt.walk_phase = drqc_pkg::PH_DONE;
						end else begin
							nxt.options_size = cur.options_size + drqc_pkg::POS_W'(1);
							if (word.data_byte != drqc_pkg::OPT_PAD)
								nxt.walk_phase = drqc_pkg::PH_LEN;
						end
					end
					drqc_pkg::PH_LEN: begin
						nxt.options_size = cur.options_size + drqc_pkg::POS_W'(1);
						nxt.skip_left = word.data_byte;
						nxt.walk_phase = (word.data_byte == 8'd0) ? drqc_pkg::PH_CODE
							: drqc_pkg::PH_SKIP;
					end
					drqc_pkg::PH_SKIP: begin
						nxt.options_size = cur.options_size + drqc_pkg::POS_W'(1);
						nxt.skip_left = skip_dec;
						if (skip_dec == 8'd0)
							nxt.walk_phase = drqc_pkg::PH_CODE;
					end
					default: begin
						nxt.walk_phase = drqc_pkg::PH_DONE;
					end
				endcase
			end
		end
	end

	assign trunc = int'(nxt.options_size) > drqc_pkg::MAX_OPTION_BYTES;

	always_comb begin
		result.client_mac = word.source_mac;
		result.options_length = '0;
		result.was_truncated = 1'b0;
		if (ap_mode && !word.from_guest_if)
			result.verdict = drqc_pkg::V_MODE;
		else if (int'(nxt.byte_position) < drqc_pkg::MIN_PACKET_BYTES)
			result.verdict = drqc_pkg::V_SHORT;
		else if (nxt.first_fail_code != drqc_pkg::V_OK)
			result.verdict = nxt.first_fail_code;
		else if (!nxt.end_seen || nxt.options_size == '0)
			result.verdict = drqc_pkg::V_CORRUPT;
		else begin
			result.verdict = drqc_pkg::V_OK;
			result.was_truncated = trunc;
			result.options_length = trunc
				? drqc_pkg::LEN_W'(drqc_pkg::MAX_OPTION_BYTES)
				: drqc_pkg::LEN_W'(nxt.options_size);
		end
	end

endmodule

[sv/dhcp_request_option_checker_unit.sv]
// A packet's verdict word passes the input register, then the result register, once the
// last byte of the packet is accepted.
// Throughput: one byte per cycle unless stalled, set by the single-byte s1-to-result step.
// A new byte is taken while a verdict waits; only a last byte held in s1 waits for space.
// Reset (arst_n low, asynchronous): clears ap_mode, parse state and both valid flags.
// ----------------------------------------------------------------------------
// DHCP request option checker
// Checks a DHCP request byte stream and walks its option TLVs, one verdict per packet.
// ----------------------------------------------------------------------------
`include "dhcp_request_option_checker_unit_assert.svh"

module dhcp_request_option_checker_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  drqc_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output drqc_pkg::out_word_t out_word
);

	// Configuration: AP-mode filter bit
	logic ap_mode_q;

	// Input stage: one accepted byte word
	logic valid_s1;
	drqc_pkg::in_word_t word_s1;

	// Per-packet parse state, updated as each s1 word retires
	drqc_pkg::parse_state_t state_q;
	drqc_pkg::parse_state_t state_nxt;

	// Result register
	logic out_valid_q;
	drqc_pkg::out_word_t out_word_q;
	drqc_pkg::out_word_t result;

	logic in_accept;
	logic adv_s1;
	logic retire_last;

	// A non-last word never needs the result register, so it always retires.
	// A last word retires once the result register is free or draining.
	assign adv_s1 = !word_s1.last_byte || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;
	assign retire_last = valid_s1 && adv_s1 && word_s1.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ap_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ap_mode_q <= cfg_wr_data;
		end
	end

	// Input register: load on accept, drop when the word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_s1 <= in_word;
		end
	end

	drqc_step u_step (
		.cur     (state_q),
		.word    (word_s1),
		.ap_mode (ap_mode_q),
		.nxt     (state_nxt),
		.result  (result)
	);

	// Advance the parse state; clear it after the last byte so the next packet starts fresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drqc_pkg::STATE_CLEAR;
		end else if (valid_s1 && adv_s1) begin
			state_q <= word_s1.last_byte ? drqc_pkg::STATE_CLEAR : state_nxt;
		end
	end

	// Result register: capture the verdict, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire_last) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	// Length fields are only meaningful on an ok verdict
	`DRQC_ASSERT_SAME(a_len_only_ok,
		out_valid_q && out_word_q.verdict != drqc_pkg::V_OK,
		out_word_q.options_length == '0 && !out_word_q.was_truncated)
	// Position saturates at the packet limit
	`DRQC_ASSERT_SAME(a_pos_sat, 1'b1,
		int'(state_q.byte_position) <= drqc_pkg::MAX_PACKET_BYTES)
	// A skip phase always has data bytes left
	`DRQC_ASSERT_SAME(a_skip_nonzero, state_q.walk_phase == drqc_pkg::PH_SKIP,
		state_q.skip_left != 8'd0)
	// Retiring a last byte starts the next packet from offset zero with a result pending
	`DRQC_ASSERT_NEXT(a_last_clears, retire_last,
		state_q.byte_position == '0 && out_valid_q)

endmodule
